>>> hdl/ptrs_pkg.sv
// Shared types and constants for the periodic task release scheduler.
// No dependencies.
`default_nettype none
package ptrs_pkg;

  localparam int unsigned TaskCountDef = 16;

  localparam logic [1:0] RunDormant   = 2'd0;
  localparam logic [1:0] RunReady     = 2'd1;
  localparam logic [1:0] RunSuspended = 2'd2;

  localparam logic [2:0] CmdTick    = 3'd0;
  localparam logic [2:0] CmdCreate  = 3'd1;
  localparam logic [2:0] CmdRemove  = 3'd2;
  localparam logic [2:0] CmdResume  = 3'd3;
  localparam logic [2:0] CmdSuspend = 3'd4;
  localparam logic [2:0] CmdReport  = 3'd5;

  localparam logic CfgEnabled  = 1'b0;
  localparam logic CfgTickStep = 1'b1;

  typedef enum logic [2:0] {
    KindReject,
    KindTick,
    KindCreate,
    KindRemove,
    KindResume,
    KindSuspend,
    KindReport
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  idx;
    logic [15:0] period;
    logic [7:0]  first_delay;
  } cmd_t;

  typedef struct packed {
    logic       ok;
    logic       rel;
    logic [3:0] task_id;
    logic [1:0] run_state;
    logic       last;
  } res_t;

endpackage
`default_nettype wire

>>> hdl/periodic_task_release_scheduler_core.sv
// Top level of the periodic task release scheduler: config registers,
// front end, back end and result queue. Depends on ptrs_pkg, ptrs_front,
// ptrs_back and ptrs_fifo.
//
//   channel   | handshake                | payload
//   ----------+--------------------------+---------------------------------------
//   command   | push / full              | command, task_index, period, first_delay
//   result    | empty / pop              | accepted_ok, released, released_task,
//             |                          | task_state, last
//   config    | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// The back end handles a non-tick command in its idle state, on the pop from the queue.
// A tick sweeps every slot: an empty or countdown slot is settled in the scan state,
// a periodic slot also passes the divide state (the bit-serial tick_count mod period
// remainder) and the eval state; setup is done in idle, the done state ends the sweep.
// Reset clears the task table and all control state at once; no clearing pass.
// A full result queue stalls the sweep; commands queue up to two deep meanwhile.
`default_nettype none
module periodic_task_release_scheduler_core #(
  parameter int unsigned TASK_COUNT = ptrs_pkg::TaskCountDef
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // command queue side
  input  wire         push,
  output logic        full,
  input  wire  [2:0]  command_i,
  input  wire  [3:0]  task_index_i,
  input  wire  [15:0] period_i,
  input  wire  [7:0]  first_delay_i,
  // result queue side
  output logic        empty,
  input  wire         pop,
  output logic        accepted_ok_o,
  output logic        released_o,
  output logic [3:0]  released_task_o,
  output logic [1:0]  task_state_o,
  output logic        last_o,
  // config writes
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire         cfg_index_i,
  input  wire  [7:0]  cfg_data_i
);

  logic           enabled_q;
  logic [7:0]     tick_step_q;
  logic           cmd_empty, cmd_pop;
  ptrs_pkg::cmd_t cmd;
  logic           res_full, res_push;
  ptrs_pkg::res_t res_in, res_out;

  // Config is always writable; the user is to change it only while idle, which the block itself does not enforce.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q   <= 1'b0;
      tick_step_q <= 8'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ptrs_pkg::CfgEnabled:  enabled_q   <= cfg_data_i[0];
        ptrs_pkg::CfgTickStep: tick_step_q <= cfg_data_i;
        default:               enabled_q   <= enabled_q;
      endcase
    end
  end

  ptrs_front #(.TASK_COUNT(TASK_COUNT)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .enabled_i    (enabled_q),
    .push_i       (push),
    .full_o       (full),
    .command_i    (command_i),
    .task_index_i (task_index_i),
    .period_i     (period_i),
    .first_delay_i(first_delay_i),
    .cmd_pop_i    (cmd_pop),
    .cmd_empty_o  (cmd_empty),
    .cmd_o        (cmd)
  );

  ptrs_back #(.TASK_COUNT(TASK_COUNT)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_step_i(tick_step_q),
    .cmd_empty_i(cmd_empty),
    .cmd_pop_o  (cmd_pop),
    .cmd_i      (cmd),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  // result queue decouples the sweep from the consumer
  ptrs_fifo #(.T(ptrs_pkg::res_t)) u_resq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (res_out)
  );

  assign accepted_ok_o   = res_out.ok;
  assign released_o      = res_out.rel;
  assign released_task_o = res_out.task_id;
  assign task_state_o    = res_out.run_state;
  assign last_o          = res_out.last;

endmodule
`default_nettype wire

>>> hdl/ptrs_fifo.sv
// Two-entry queue of an arbitrary packed type.
// Used between front and back and for results; no package dependency.
`default_nettype none
module ptrs_fifo #(
  parameter type T = logic
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  push_i,
  input  T     data_i,
  output logic full_o,
  input  wire  pop_i,
  output logic empty_o,
  output T     data_o
);

  T           mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

>>> hdl/ptrs_front.sv
// Front end: classifies incoming commands and queues them for the back end.
// Depends on ptrs_pkg and ptrs_fifo.
`default_nettype none
module ptrs_front #(
  parameter int unsigned TASK_COUNT = ptrs_pkg::TaskCountDef
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               enabled_i,
  input  wire               push_i,
  output logic              full_o,
  input  wire        [2:0]  command_i,
  input  wire        [3:0]  task_index_i,
  input  wire        [15:0] period_i,
  input  wire        [7:0]  first_delay_i,
  input  wire               cmd_pop_i,
  output logic              cmd_empty_o,
  output ptrs_pkg::cmd_t    cmd_o
);

  ptrs_pkg::cmd_t cmd_w;
  logic           idx_ok;

  assign idx_ok = ({1'b0, task_index_i} < 5'(TASK_COUNT > 16 ? 16 : TASK_COUNT))
                  || (TASK_COUNT > 16);

  always_comb begin
    cmd_w.idx         = task_index_i;
    cmd_w.period      = period_i;
    cmd_w.first_delay = first_delay_i;
    cmd_w.kind        = ptrs_pkg::KindReject;
    if (enabled_i) begin
      unique case (command_i)
        ptrs_pkg::CmdTick:    cmd_w.kind = ptrs_pkg::KindTick;
        ptrs_pkg::CmdCreate:  if (idx_ok && period_i != 16'd0) cmd_w.kind = ptrs_pkg::KindCreate;
        ptrs_pkg::CmdRemove:  if (idx_ok) cmd_w.kind = ptrs_pkg::KindRemove;
        ptrs_pkg::CmdResume:  if (idx_ok) cmd_w.kind = ptrs_pkg::KindResume;
        ptrs_pkg::CmdSuspend: if (idx_ok) cmd_w.kind = ptrs_pkg::KindSuspend;
        ptrs_pkg::CmdReport:  if (idx_ok) cmd_w.kind = ptrs_pkg::KindReport;
        default:              cmd_w.kind = ptrs_pkg::KindReject;
      endcase
    end
  end

  ptrs_fifo #(.T(ptrs_pkg::cmd_t)) u_cmdq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (cmd_w),
    .full_o (full_o),
    .pop_i  (cmd_pop_i),
    .empty_o(cmd_empty_o),
    .data_o (cmd_o)
  );

endmodule
`default_nettype wire

>>> hdl/ptrs_back.sv
// Back end: task table, tick sweep with a bit-serial remainder unit.
// Depends on ptrs_pkg.
`default_nettype none
module ptrs_back #(
  parameter int unsigned TASK_COUNT = ptrs_pkg::TaskCountDef
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire       [7:0] tick_step_i,
  input  wire             cmd_empty_i,
  output logic            cmd_pop_o,
  input  ptrs_pkg::cmd_t  cmd_i,
  input  wire             res_full_i,
  output logic            res_push_o,
  output ptrs_pkg::res_t  res_o
);

  localparam int unsigned IdxW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam logic [IdxW-1:0] LastSlot = IdxW'(TASK_COUNT - 1);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StEval = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  logic [2:0]      st_q, st_d;
  logic [31:0]     tick_q, tick_d;
  logic [IdxW-1:0] slot_q, slot_d;
  logic [IdxW-1:0] pend_q, pend_d;
  logic            pend_v_q, pend_v_d;
  logic [15:0]     rem_q, rem_d;
  logic [31:0]     dvd_q, dvd_d;
  logic [4:0]      cnt_q, cnt_d;

  logic            created_q [TASK_COUNT];
  logic            cdmode_q  [TASK_COUNT];
  logic [1:0]      run_q     [TASK_COUNT];
  logic [15:0]     per_q     [TASK_COUNT];
  logic [15:0]     cd_q      [TASK_COUNT];

  logic [IdxW-1:0] cs;
  logic            tbl_we;
  logic            tbl_create;
  logic [1:0]      tbl_run;
  logic            cd_we;
  logic [15:0]     cd_new;
  logic            eval_en, fire, rel, advance;
  logic [16:0]     div_r;

  assign cs    = IdxW'(cmd_i.idx);
  assign div_r = {rem_q, dvd_q[31]};

  always_comb begin
    st_d       = st_q;
    tick_d     = tick_q;
    slot_d     = slot_q;
    pend_d     = pend_q;
    pend_v_d   = pend_v_q;
    rem_d      = rem_q;
    dvd_d      = dvd_q;
    cnt_d      = cnt_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    tbl_we     = 1'b0;
    tbl_create = 1'b0;
    tbl_run    = ptrs_pkg::RunReady;
    cd_we      = 1'b0;
    cd_new     = cd_q[slot_q];
    eval_en    = 1'b0;
    fire       = 1'b0;
    advance    = 1'b0;

    unique case (st_q)
      StIdle: begin
        if (!cmd_empty_i && !res_full_i) begin
          cmd_pop_o   = 1'b1;
          res_o.ok    = 1'b1;
          res_o.last  = 1'b1;
          res_push_o  = 1'b1;
          unique case (cmd_i.kind)
            ptrs_pkg::KindReject: res_o.ok = 1'b0;
            ptrs_pkg::KindTick: begin
              res_push_o = 1'b0;
              tick_d     = tick_q + 32'(tick_step_i);
              slot_d     = '0;
              pend_v_d   = 1'b0;
              st_d       = StScan;
            end
            ptrs_pkg::KindCreate: begin
              tbl_we     = 1'b1;
              tbl_create = 1'b1;
            end
            ptrs_pkg::KindRemove: begin
              tbl_we  = 1'b1;
              tbl_run = ptrs_pkg::RunDormant;
            end
            ptrs_pkg::KindResume: tbl_we = 1'b1;
            ptrs_pkg::KindSuspend: begin
              tbl_we  = 1'b1;
              tbl_run = ptrs_pkg::RunSuspended;
            end
            ptrs_pkg::KindReport: res_o.run_state = run_q[cs];
            default: res_o.ok = 1'b0;
          endcase
        end
      end
      StScan: begin
        if (!created_q[slot_q]) begin
          advance = 1'b1;
        end else if (cdmode_q[slot_q]) begin
          eval_en = 1'b1;
          fire    = (cd_q[slot_q] <= {8'd0, tick_step_i});
        end else begin
          rem_d = '0;
          dvd_d = tick_q;
          cnt_d = '0;
          st_d  = StDiv;
        end
      end
      StDiv: begin
        rem_d = (div_r >= {1'b0, per_q[slot_q]}) ? 16'(div_r - {1'b0, per_q[slot_q]})
                                                  : 16'(div_r);
        dvd_d = {dvd_q[30:0], 1'b0};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) st_d = StEval;
      end
      StEval: begin
        eval_en = 1'b1;
        fire    = (rem_q == 16'd0) && (per_q[slot_q] != 16'd0);
      end
      StDone: begin
        if (!res_full_i) begin
          res_push_o    = 1'b1;
          res_o.ok      = 1'b1;
          res_o.rel     = pend_v_q;
          res_o.task_id = pend_v_q ? 4'(pend_q) : 4'd0;
          res_o.last    = 1'b1;
          st_d          = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase

    rel = fire && (run_q[slot_q] == ptrs_pkg::RunReady);
    // A second release has to flush the held one; wait if the result queue is full.
    if (eval_en && !(rel && pend_v_q && res_full_i)) begin
      advance = 1'b1;
      if (cdmode_q[slot_q]) begin
        cd_we  = 1'b1;
        cd_new = fire ? per_q[slot_q] : 16'(cd_q[slot_q] - {8'd0, tick_step_i});
      end
      if (rel) begin
        if (pend_v_q) begin
          res_push_o    = 1'b1;
          res_o.ok      = 1'b1;
          res_o.rel     = 1'b1;
          res_o.task_id = 4'(pend_q);
        end
        pend_d   = slot_q;
        pend_v_d = 1'b1;
      end
    end

    if (advance) begin
      if (slot_q == LastSlot) begin
        st_d = StDone;
      end else begin
        slot_d = slot_q + IdxW'(1);
        st_d   = StScan;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      tick_q   <= '0;
      slot_q   <= '0;
      pend_q   <= '0;
      pend_v_q <= 1'b0;
      for (int i = 0; i < int'(TASK_COUNT); i++) begin
        created_q[i] <= 1'b0;
        cdmode_q[i]  <= 1'b0;
        run_q[i]     <= ptrs_pkg::RunDormant;
        per_q[i]     <= '0;
        cd_q[i]      <= '0;
      end
    end else begin
      st_q     <= st_d;
      tick_q   <= tick_d;
      slot_q   <= slot_d;
      pend_q   <= pend_d;
      pend_v_q <= pend_v_d;
      if (tbl_we) begin
        run_q[cs] <= tbl_run;
        if (tbl_create) begin
          created_q[cs] <= 1'b1;
          per_q[cs]     <= cmd_i.period;
          cd_q[cs]      <= 16'(cmd_i.first_delay);
          cdmode_q[cs]  <= (cmd_i.first_delay != 8'd0);
        end
      end
      if (cd_we) cd_q[slot_q] <= cd_new;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    cnt_q <= cnt_d;
  end

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i) else $error("result pushed into full queue");
  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (st_q == StIdle) && !cmd_empty_i) else $error("bad command pop");
  a_tick_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop_o && cmd_i.kind == ptrs_pkg::KindTick)
      |=> tick_q == $past(tick_q) + 32'($past(tick_step_i)))
    else $error("tick count did not advance");
  a_tick_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |=> $stable(tick_q)) else $error("tick count moved mid sweep");
`endif

endmodule
`default_nettype wire
